[src/sha_pkg.sv]
`default_nettype none
package sha_pkg;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       has_byte;
        logic       end_of_message;
    } sha_in_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } sha_out_t;

    // Command from front to back
    typedef enum logic [1:0] {
        CMD_BYTE = 2'd0,
        CMD_END  = 2'd1,
        CMD_BOTH = 2'd2
    } sha_cmd_e;

    typedef struct packed {
        sha_cmd_e   cmd;
        logic [7:0] data;
    } sha_cmd_t;

    localparam int CmdDepth = 4;
    localparam int CmdAw    = 2;

    typedef logic [31:0] word_t;

    localparam word_t RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam word_t InitHash [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam int LenStart = 56;

    function automatic word_t rotr(input word_t x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage
`default_nettype wire

[src/sha256_stream_hasher.sv]
`default_nettype none
// Channel   Handshake       Payload
// in        push / full     sha_in_t  {byte_value, has_byte, end_of_message}
// out       pop / empty     sha_out_t {digest_word, word_index, last_word}
//
// A byte item is taken while the engine is idle; every 64th byte adds a
// compression (load, 64 rounds at one per cycle, add).
// An end item pads one byte per cycle, compresses once or twice and emits
// eight words, one per cycle while the output register drains.
// Reset loads the initial hash and clears counts; no clearing pass.
// A four-entry command queue lets input keep arriving while the engine works.
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire sha_in_t in_item,
    input  wire logic    push,
    output logic         full,
    output sha_out_t     out_item,
    output logic         empty,
    input  wire logic    pop
);

    sha_cmd_t cmd;
    logic     cmd_valid, cmd_take;

    sha_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .push      (push),
        .full      (full),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take)
    );

    sha_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .result    (out_item),
        .empty     (empty),
        .pop       (pop)
    );

endmodule
`default_nettype wire

[src/sha_front.sv]
`default_nettype none
// Classify input items and queue commands for the engine.
module sha_front
    import sha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire sha_in_t  in_item,
    input  wire logic     push,
    output logic          full,
    output sha_cmd_t      cmd,
    output logic          cmd_valid,
    input  wire logic     cmd_take
);

    sha_cmd_t            q_reg [CmdDepth];
    logic [CmdAw-1:0]    wr_reg, wr_next, rd_reg, rd_next;
    logic [CmdAw:0]      cnt_reg, cnt_next;
    logic                do_push, do_pop, useful;
    sha_cmd_t            new_cmd;

    // Map item to command; drop items with neither byte nor end
    always_comb
    begin
        useful       = in_item.has_byte | in_item.end_of_message;
        new_cmd.data = in_item.byte_value;
        if (in_item.has_byte && in_item.end_of_message)
        begin
            new_cmd.cmd = CMD_BOTH;
        end
        else if (in_item.has_byte)
        begin
            new_cmd.cmd = CMD_BYTE;
        end
        else
        begin
            new_cmd.cmd = CMD_END;
        end
    end

    assign full      = (cnt_reg == (CmdAw+1)'(CmdDepth));
    assign cmd_valid = (cnt_reg != '0);
    assign cmd       = q_reg[rd_reg];
    assign do_push   = push && !full && useful;
    assign do_pop    = cmd_take && cmd_valid;

    // Advance pointers
    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (CmdAw+1)'(do_push) - (CmdAw+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Hold queue payload
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_reg] <= new_cmd;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        full |=> cnt_reg == (CmdAw+1)'(CmdDepth) || $past(do_pop))
        else $error("queue count changed while full without pop");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= (CmdAw+1)'(CmdDepth))
        else $error("queue count out of range");
    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == '0 |-> wr_reg == rd_reg)
        else $error("empty queue with pointer gap");
`endif

endmodule
`default_nettype wire

[src/sha_back.sv]
`default_nettype none
// Buffer bytes, pad, compress and emit digest words.
module sha_back
    import sha_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire sha_cmd_t cmd,
    input  wire logic     cmd_valid,
    output logic          cmd_take,
    output sha_out_t      result,
    output logic          empty,
    input  wire logic     pop
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PAD   = 6'b000010,
        S_LOAD  = 6'b000100,
        S_ROUND = 6'b001000,
        S_ADD   = 6'b010000,
        S_EMIT  = 6'b100000
    } state_t;

    state_t        state_reg, state_next;
    word_t         hash_reg [8];
    word_t         blk_reg  [16];   // block buffer as 16 words, doubles as schedule
    word_t         v_reg    [8];
    logic [6:0]    fill_reg;
    logic [60:0]   bytes_reg;
    logic [5:0]    round_reg;
    logic          final_reg;       // end of message seen; this block or the next one ends it
    logic          padded_reg;      // 0x80 already placed
    logic [2:0]    idx_reg;
    logic          out_valid_reg;
    word_t         out_word_reg;
    logic [2:0]    out_idx_reg;
    logic          len_ok_reg;
    logic          len_ok;

    logic [63:0]   bits;
    word_t         w, w15, w2, s0w, s1w, t1, t2, s1, s0, ch, mj;
    logic          byte_in, end_in, slot_free;

    assign bits     = {bytes_reg, 3'b000};
    assign byte_in  = (cmd.cmd == CMD_BYTE) || (cmd.cmd == CMD_BOTH);
    assign end_in   = (cmd.cmd == CMD_END) || (cmd.cmd == CMD_BOTH);
    assign cmd_take = (state_reg == S_IDLE) && cmd_valid;
    assign slot_free = !out_valid_reg || pop;

    assign empty              = !out_valid_reg;
    assign result.digest_word = out_word_reg;
    assign result.word_index  = out_idx_reg;
    assign result.last_word   = (out_idx_reg == 3'd7);

    // Round datapath; window shifts so word i always sits at index 0
    always_comb
    begin
        w15 = blk_reg[1];
        w2  = blk_reg[14];
        s0w = rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3);
        s1w = rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10);
        w   = blk_reg[0];
        s1  = rotr(v_reg[4], 6) ^ rotr(v_reg[4], 11) ^ rotr(v_reg[4], 25);
        ch  = (v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]);
        t1  = v_reg[7] + s1 + ch + RoundK[round_reg] + w;
        s0  = rotr(v_reg[0], 2) ^ rotr(v_reg[0], 13) ^ rotr(v_reg[0], 22);
        mj  = (v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]);
        t2  = s0 + mj;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    if (byte_in && fill_reg == 7'd63)
                    begin
                        state_next = S_LOAD;
                    end
                    else if (end_in)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                if (fill_reg == 7'd64)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:  state_next = S_ROUND;
            S_ROUND:
            begin
                if (round_reg == 6'd63)
                begin
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                // Emit once the block that carried the length is done
                if (final_reg && padded_reg && len_ok)
                begin
                    state_next = S_EMIT;
                end
                else if (final_reg)
                begin
                    state_next = S_PAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_EMIT:
            begin
                if (slot_free && idx_reg == 3'd7)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            bytes_reg     <= '0;
            round_reg     <= '0;
            final_reg     <= 1'b0;
            padded_reg    <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 8; i++)
            begin
                hash_reg[i] <= InitHash[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            // Load the output register on a new word, clear it on a transfer
            if (state_reg == S_EMIT && slot_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (pop && out_valid_reg)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (byte_in)
                        begin
                            fill_reg  <= fill_reg + 7'd1;
                            bytes_reg <= bytes_reg + 61'd1;
                        end
                        final_reg  <= end_in;
                        padded_reg <= 1'b0;
                    end
                end
                S_PAD:
                begin
                    // One byte per cycle: marker, zeros, then length
                    if (fill_reg != 7'd64)
                    begin
                        fill_reg <= fill_reg + 7'd1;
                        if (!padded_reg)
                        begin
                            padded_reg <= 1'b1;
                        end
                    end
                end
                S_LOAD:
                begin
                    round_reg <= '0;
                    fill_reg  <= '0;
                end
                S_ROUND:
                begin
                    round_reg <= round_reg + 6'd1;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        hash_reg[i] <= hash_reg[i] + v_reg[i];
                    end
                    idx_reg <= '0;
                end
                S_EMIT:
                begin
                    if (slot_free)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++)
                            begin
                                hash_reg[i] <= InitHash[i];
                            end
                            bytes_reg  <= '0;
                            final_reg  <= 1'b0;
                            padded_reg <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Payload: buffer writes, working variables, output word
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && byte_in)
                begin
                    blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= cmd.data;
                end
            end
            S_PAD:
            begin
                if (fill_reg != 7'd64)
                begin
                    if (!padded_reg)
                    begin
                        blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= PadByte;
                    end
                    else if (fill_reg >= 7'(LenStart))
                    begin
                        // Length bytes only fit in the block that ends the message
                        blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <=
                            len_ok ? bits[8*(63-fill_reg[5:0]) +: 8] : 8'h00;
                    end
                    else
                    begin
                        blk_reg[fill_reg[5:2]][8*(3-fill_reg[1:0]) +: 8] <= 8'h00;
                    end
                end
            end
            S_LOAD:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    v_reg[i] <= hash_reg[i];
                end
            end
            S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    blk_reg[i] <= blk_reg[i+1];
                end
                blk_reg[15] <= blk_reg[0] + s0w + blk_reg[9] + s1w;
                v_reg[7] <= v_reg[6];
                v_reg[6] <= v_reg[5];
                v_reg[5] <= v_reg[4];
                v_reg[4] <= v_reg[3] + t1;
                v_reg[3] <= v_reg[2];
                v_reg[2] <= v_reg[1];
                v_reg[1] <= v_reg[0];
                v_reg[0] <= t1 + t2;
            end
            S_EMIT:
            begin
                if (slot_free)
                begin
                    out_word_reg <= hash_reg[idx_reg];
                    out_idx_reg  <= idx_reg;
                end
            end
            default: ;
        endcase
    end

    // Length goes in this block only if the marker landed at or before byte 55, else in the next block
    assign len_ok = len_ok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_ok_reg <= 1'b0;
        end
        else if (state_reg == S_PAD && !padded_reg)
        begin
            len_ok_reg <= (fill_reg < 7'(LenStart));
        end
        else if (state_reg == S_ADD)
        begin
            len_ok_reg <= 1'b1;
        end
    end

`ifndef SYNTH
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == S_IDLE)
        else $error("command taken while busy");
    a_round_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ROUND && round_reg != 6'd63 |=> state_reg == S_ROUND)
        else $error("round loop left early");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 7'd64)
        else $error("fill overran block");
`endif

endmodule
`default_nettype wire
